// ----- rtl/ssii_pkg.sv -----
`default_nettype none
package ssii_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STEP_W   = $clog2(CAPACITY);

    typedef logic signed [31:0] t_elem;

    typedef enum logic [2:0] {
        REQ_CLEAR = 3'd0,
        REQ_ADD   = 3'd1,
        REQ_PROBE = 3'd2,
        REQ_EMIT  = 3'd3,
        REQ_DUMP  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_ELEM  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_CLEAR  = 3'd1,
        CELL_UNMARK = 3'd2,
        CELL_INSERT = 3'd3,
        CELL_PROBE  = 3'd4,
        CELL_ROTATE = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_elem    value;
    } t_cell_cmd;

    typedef struct packed {
        logic  valid;
        logic  mark;
        logic  gt;
        t_elem value;
    } t_cell_link;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] elem_value;
        logic               last;
        logic [4:0]         fill_count;
    } t_out_beat;

endpackage
`default_nettype wire

// ----- rtl/ssii_cell.sv -----
`default_nettype none
module ssii_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssii_pkg::t_cell_cmd  i_cmd,
    input  ssii_pkg::t_cell_link i_left,
    input  ssii_pkg::t_cell_link i_right,
    output ssii_pkg::t_cell_link o_link
);
    import ssii_pkg::*;

    t_elem r_value, n_value;
    logic  r_valid, n_valid;
    logic  r_mark, n_mark;
    logic  gt;

    assign gt = r_valid && (r_value > i_cmd.value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        n_mark  = r_mark;
        unique case (i_cmd.op)
            CELL_HOLD: begin
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
                n_mark  = 1'b0;
            end
            CELL_UNMARK: begin
                n_mark = 1'b0;
            end
            CELL_INSERT: begin
                n_mark = 1'b0;
                if (gt || (!r_valid && i_left.valid)) begin
                    n_value = i_left.gt ? i_left.value : i_cmd.value;
                    n_valid = 1'b1;
                end
            end
            CELL_PROBE: begin
                if (r_valid && (r_value == i_cmd.value)) begin
                    n_mark = 1'b1;
                end
            end
            CELL_ROTATE: begin
                n_value = i_right.value;
                n_valid = i_right.valid;
                n_mark  = i_right.mark;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_mark  <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, mark: r_mark, gt: gt, value: r_value};

endmodule
`default_nettype wire

// ----- rtl/sorted_set_insert_intersect.sv -----
// Sorted multiset store with intersection marking.
// Input channel (i_valid/o_ready, i_data) carries one request per beat:
// clear, add, probe, emit or dump. Output channel (o_valid/i_ready, o_data)
// carries result beats; the final beat of each request has last set.
// Values sit in a row of CAPACITY cells kept in ascending order.
// Clear, add and probe update the cell row on acceptance; their single result
// beat is registered and shows in the cycle after acceptance. Such requests
// can be accepted every cycle while the receiver takes results.
// Emit and dump rotate the whole row once through cell 0, CAPACITY steps,
// then one closing step. Each element that qualifies (marked for emit, any
// for dump) is held until the next one is found; the last one leaves at the
// closing step. No new request is accepted until the closing beat is
// registered. Request codes 5 to 7 are accepted and dropped.
// A stalled output register holds the row: rotation advances only when the
// output register is free or being taken.
// Synchronous active-low reset empties the store and clears all marks.
`default_nettype none
module sorted_set_insert_intersect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ssii_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ssii_pkg::t_out_beat o_data
);
    import ssii_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_dump, n_dump;
    logic                 r_pend_valid, n_pend_valid;
    t_elem                r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    t_cell_cmd            cell_cmd;
    t_cell_link           links [CAPACITY];
    t_cell_link           wrap_link;
    logic [CAPACITY-1:0]  valid_vec;
    logic                 out_free, accept, full, qual;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign qual     = links[0].valid && (r_dump || links[0].mark);

    assign wrap_link = '{valid: links[0].valid, mark: links[0].mark && r_dump,
                         gt: 1'b0, value: links[0].value};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_cell_link left_in, right_in;
            if (g == 0) begin : g_first
                assign left_in = '{valid: 1'b1, mark: 1'b0, gt: 1'b0, value: '0};
            end else begin : g_mid
                assign left_in = links[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_in = wrap_link;
            end else begin : g_body
                assign right_in = links[g+1];
            end
            ssii_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cell_cmd),
                .i_left  (left_in),
                .i_right (right_in),
                .o_link  (links[g])
            );
            assign valid_vec[g] = links[g].valid;
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_dump       = r_dump;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        cell_cmd     = '{op: CELL_HOLD, value: i_data.value};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out.elem_value = '0;
                    n_out.last       = 1'b1;
                    n_out.status     = STAT_OK;
                    unique case (i_data.req_type) inside
                        REQ_CLEAR: begin
                            cell_cmd.op = CELL_CLEAR;
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                        REQ_ADD: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                cell_cmd.op  = CELL_UNMARK;
                                n_out.status = STAT_FULL;
                            end else begin
                                cell_cmd.op = CELL_INSERT;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        REQ_PROBE: begin
                            cell_cmd.op = CELL_PROBE;
                            n_out_valid = 1'b1;
                        end
                        REQ_EMIT, REQ_DUMP: begin
                            n_state      = ST_SWEEP;
                            n_step       = '0;
                            n_dump       = (i_data.req_type == REQ_DUMP);
                            n_pend_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    n_out.fill_count = 5'(n_count);
                end
            end
            ST_SWEEP: begin
                if (out_free) begin
                    cell_cmd.op = CELL_ROTATE;
                    if (qual) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: STAT_ELEM, elem_value: r_pend,
                                            last: 1'b0, fill_count: 5'(r_count)};
                        end
                        n_pend       = links[0].value;
                        n_pend_valid = 1'b1;
                    end
                    n_step = r_step + STEP_W'(1);
                    if (r_step == STEP_W'(CAPACITY - 1)) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend_valid
                        ? t_out_beat'{status: STAT_ELEM, elem_value: r_pend, last: 1'b1,
                                      fill_count: 5'(r_count)}
                        : t_out_beat'{status: STAT_EMPTY, elem_value: '0, last: 1'b1,
                                      fill_count: 5'(r_count)};
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_dump       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_step       <= n_step;
            r_dump       <= n_dump;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("occupied cells disagree with element count");

    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) && out_free |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("closing beat not issued");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending element left over in idle");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssii_pkg::*;

    localparam t_elem VAL_MAX = 32'sh7fffffff;
    localparam t_elem VAL_MIN = 32'sh80000000;
    localparam int    SETTLE_CYCLES = 2 * CAPACITY + 8;

    class set_scoreboard;
        t_elem       store [CAPACITY];
        bit          marks [CAPACITY];
        int unsigned count = 0;
        t_out_beat   pending [$];
        int          mismatches = 0;
        int          beats_checked = 0;
        int          requests_seen = 0;

        function void clear_marks();
            for (int i = 0; i < CAPACITY; i++) marks[i] = 1'b0;
        endfunction

        function void push_beat(t_status st, t_elem v, bit last);
            t_out_beat b;
            b.status     = st;
            b.elem_value = v;
            b.last       = last;
            b.fill_count = count[4:0];
            pending.push_back(b);
        endfunction

        function void push_list(t_elem hits [$]);
            if (hits.size() == 0) begin
                push_beat(STAT_EMPTY, '0, 1'b1);
            end else begin
                for (int i = 0; i < hits.size(); i++)
                    push_beat(STAT_ELEM, hits[i], i == hits.size() - 1);
            end
        endfunction

        function void note_request(t_in_beat req);
            t_elem hits [$];
            int    pos;
            case (req.req_type)
                REQ_CLEAR: begin
                    count = 0;
                    clear_marks();
                    push_beat(STAT_OK, '0, 1'b1);
                end
                REQ_ADD: begin
                    clear_marks();
                    if (count >= CAPACITY) begin
                        push_beat(STAT_FULL, '0, 1'b1);
                    end else begin
                        pos = count;
                        while (pos > 0 && store[pos-1] > req.value) begin
                            store[pos] = store[pos-1];
                            pos--;
                        end
                        store[pos] = req.value;
                        count++;
                        push_beat(STAT_OK, '0, 1'b1);
                    end
                end
                REQ_PROBE: begin
                    for (int i = 0; i < count; i++)
                        if (store[i] == req.value) marks[i] = 1'b1;
                    push_beat(STAT_OK, '0, 1'b1);
                end
                REQ_EMIT: begin
                    for (int i = 0; i < count; i++)
                        if (marks[i]) hits.push_back(store[i]);
                    clear_marks();
                    push_list(hits);
                end
                REQ_DUMP: begin
                    for (int i = 0; i < count; i++) hits.push_back(store[i]);
                    push_list(hits);
                end
                default: ;
            endcase
            if (req.req_type <= REQ_DUMP) requests_seen++;
        endfunction

        function void flag(string what, t_out_beat exp, t_out_beat got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected st=%0d val=%0d last=%0d fill=%0d,",
                          " got st=%0d val=%0d last=%0d fill=%0d"},
                         what, exp.status, exp.elem_value, exp.last, exp.fill_count,
                         got.status, got.elem_value, got.last, got.fill_count);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat exp;
            beats_checked++;
            if (pending.size() == 0) begin
                flag("unexpected beat", '0, got);
            end else begin
                exp = pending.pop_front();
                if (got.status !== exp.status || got.elem_value !== exp.elem_value ||
                    got.last !== exp.last || got.fill_count !== exp.fill_count)
                    flag("beat mismatch", exp, got);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    set_scoreboard board = new;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_holdoff = 0;
    int items_sent = 0;

    sorted_set_insert_intersect dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (rx_holdoff > 0) begin
            i_ready = 1'b0;
            rx_holdoff--;
        end else begin
            i_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_request(i_data);
            if (o_valid && i_ready) board.check_beat(o_data);
        end
    end

    initial begin
        #5_000_000;
        $display("sorted_set_insert_intersect test failed");
        $finish;
    end

    task automatic send_request(input logic [2:0] kind, input t_elem val);
        t_in_beat beat;
        beat.req_type = kind;
        beat.value    = val;
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (kind <= REQ_DUMP) items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_elem pick_value();
        case ($urandom_range(9)) inside
            0, 1, 2, 3: return t_elem'($urandom_range(8)) - 4;
            4: begin
                case ($urandom_range(3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default: return t_elem'($urandom);
        endcase
    endfunction

    task automatic run_session();
        t_elem added [$];
        t_elem v;
        int    n_add;
        if ($urandom_range(99) < 20) begin
            repeat (6) send_request(3'($urandom_range(7)), t_elem'($urandom));
            return;
        end
        if ($urandom_range(99) < 75) send_request(REQ_CLEAR, t_elem'($urandom));
        n_add = ($urandom_range(3) == 0) ? $urandom_range(14, 18) : $urandom_range(8);
        repeat (n_add) begin
            v = pick_value();
            added.push_back(v);
            send_request(REQ_ADD, v);
        end
        repeat ($urandom_range(4)) begin
            if (added.size() > 0 && $urandom_range(99) < 70)
                v = added[$urandom_range(added.size() - 1)];
            else
                v = pick_value();
            send_request(REQ_PROBE, v);
        end
        if ($urandom_range(3) == 0) send_request(REQ_ADD, pick_value());
        if ($urandom_range(9) == 0) send_request(3'($urandom_range(5, 7)), t_elem'($urandom));
        send_request(REQ_EMIT, t_elem'($urandom));
        if ($urandom_range(99) < 40) send_request(REQ_DUMP, t_elem'($urandom));
        if ($urandom_range(4) == 0) send_request(REQ_EMIT, t_elem'($urandom));
    endtask

    initial begin
        int random_goal;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(REQ_CLEAR, VAL_MAX);
        send_request(REQ_DUMP, '0);
        send_request(REQ_EMIT, '0);
        send_request(3'd7, VAL_MIN);
        send_request(REQ_ADD, VAL_MAX);
        send_request(REQ_ADD, VAL_MIN);
        send_request(REQ_ADD, '0);
        send_request(REQ_ADD, -1);
        send_request(REQ_ADD, 1);
        send_request(REQ_ADD, '0);
        send_request(REQ_PROBE, '0);
        send_request(REQ_PROBE, VAL_MIN);
        send_request(REQ_EMIT, '0);
        send_request(REQ_DUMP, '0);
        for (int k = 0; k < 10; k++) send_request(REQ_ADD, t_elem'(k * 3 - 9));
        send_request(REQ_ADD, 5);
        send_request(REQ_PROBE, VAL_MAX);
        send_request(REQ_EMIT, '0);
        send_request(REQ_DUMP, '0);
        drain();

        random_goal = items_sent + 376;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    rx_holdoff   = 300;
                end
                1: begin
                    tx_idle_pct  = 65;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 65;
                end
                default: begin
                    tx_idle_pct  = 6;
                    rx_stall_pct = 6;
                end
            endcase
            while (items_sent < random_goal - (3 - phase) * 94) run_session();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $display("%0d expected beats never arrived", board.pending.size());
            board.mismatches++;
        end
        $display("covered %0d requests and %0d result beats over four idle mixes",
                 board.requests_seen, board.beats_checked);
        $display("including a long output stall, full-store rejects and ignored codes");
        if (board.mismatches == 0) begin
            $display("sorted_set_insert_intersect test passed");
        end else begin
            $display("sorted_set_insert_intersect test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
